FILE: rtl/quoted_printable_encoder_assert.svh
// Assertion macros for the encoder checker.
`ifndef QUOTED_PRINTABLE_ENCODER_ASSERT_SVH
`define QUOTED_PRINTABLE_ENCODER_ASSERT_SVH

// Property on clk, disabled while arst_n is low.
`define QPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true.
`define QPE_ASSERT_NEVER(label, expr, msg) \
	`QPE_ASSERT(label, !(expr), msg)

`endif

FILE: rtl/qpe_pkg.sv
// Shared types, character constants and helpers of the quoted-printable encoder.
package qpe_pkg;

	// Character codes
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	// Held blank codes
	localparam logic [1:0] BLANK_NONE = 2'd0;
	localparam logic [1:0] BLANK_TAB  = 2'd1;
	localparam logic [1:0] BLANK_SP   = 2'd2;

	// Configuration register indexes
	localparam int         CFG_IDX_W      = 3;
	localparam logic [2:0] CFG_Q_MODE     = 3'd0;
	localparam logic [2:0] CFG_LIT_MAP_0  = 3'd1;
	localparam logic [2:0] CFG_LIT_MAP_1  = 3'd2;
	localparam logic [2:0] CFG_LIT_MAP_2  = 3'd3;
	localparam logic [2:0] CFG_LIT_MAP_3  = 3'd4;

	// Command slots and queue
	localparam int NUM_SLOTS   = 4;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Piece kinds carried out by the back end
	typedef enum logic [1:0] {
		OP_LIT,    // literal byte, one-byte room check
		OP_ESC,    // =XX, three-byte room check
		OP_TRAIL,  // trailing blank: one-byte check, then =XX
		OP_HARD    // hard line break CR LF
	} qpe_op_t;

	typedef struct packed {
		logic      vld;
		qpe_op_t   op;
		logic [7:0] data;
	} qpe_slot_t;

	typedef struct packed {
		qpe_slot_t [NUM_SLOTS-1:0] slot;
		logic                      last;
	} qpe_cmd_t;

	// Upper-case hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'd0, n};
		end else begin
			r = 8'h37 + {4'd0, n};
		end
		return r;
	endfunction

endpackage

FILE: rtl/qpe_front.sv
// Front end: accepts source bytes, tracks held blank and CR, builds piece commands.
module qpe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               q_mode,
	input  logic [255:0]       lit_map,
	input  logic               queue_full,
	output logic               push,
	output qpe_pkg::qpe_cmd_t  push_cmd
);
	import qpe_pkg::*;

	logic [1:0] hb_q;
	logic       hc_q;
	logic [1:0] nb_mid;
	logic       nc_mid;
	logic       is_lit, is_cr, is_lf, is_tab, is_sp;
	logic       cr_hold, consumed, has_out, accept;
	logic [7:0] blank_b;
	logic [7:0] blank_new;
	qpe_cmd_t   cmd;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Classify the byte
	always_comb begin
		is_lit    = lit_map[in_byte];
		is_cr     = (in_byte == CH_CR);
		is_lf     = (in_byte == CH_LF);
		is_tab    = (in_byte == CH_TAB);
		is_sp     = (in_byte == CH_SP);
		blank_b   = (hb_q == BLANK_TAB) ? CH_TAB : CH_SP;
		cr_hold   = !is_lit && is_cr && !q_mode;
		consumed  = hc_q && is_lf && !q_mode;
	end

	// Build the command: held blank, held CR, this byte, end flush
	always_comb begin
		cmd      = '0;
		cmd.last = in_last;
		if (hc_q) begin
			if (hb_q != BLANK_NONE) begin
				cmd.slot[0] = '{vld: 1'b1, op: consumed ? OP_TRAIL : OP_LIT, data: blank_b};
			end
			cmd.slot[1] = '{vld: 1'b1, op: consumed ? OP_HARD : OP_ESC, data: CH_CR};
		end else if (hb_q != BLANK_NONE && (!cr_hold || in_last)) begin
			cmd.slot[0] = '{vld: 1'b1, op: OP_LIT, data: blank_b};
		end

		// state after this byte, before the end flush
		if (consumed) begin
			nb_mid = BLANK_NONE;
		end else if (is_lit && is_tab) begin
			nb_mid = BLANK_TAB;
		end else if (is_lit && is_sp) begin
			nb_mid = BLANK_SP;
		end else if (cr_hold && !hc_q) begin
			nb_mid = hb_q;
		end else begin
			nb_mid = BLANK_NONE;
		end
		nc_mid = !consumed && cr_hold;

		if (!consumed) begin
			if (is_lit && !is_tab && !is_sp) begin
				cmd.slot[2] = '{vld: 1'b1, op: OP_LIT, data: in_byte};
			end else if (!is_lit && !cr_hold) begin
				cmd.slot[2] = '{vld: 1'b1, op: OP_ESC, data: in_byte};
			end
		end

		blank_new = (nb_mid == BLANK_TAB) ? CH_TAB : CH_SP;
		if (in_last) begin
			if (nc_mid) begin
				cmd.slot[3] = '{vld: 1'b1, op: OP_ESC, data: CH_CR};
			end else if (nb_mid != BLANK_NONE) begin
				cmd.slot[3] = '{vld: 1'b1, op: OP_TRAIL, data: blank_new};
			end
		end

		has_out = cmd.slot[0].vld | cmd.slot[1].vld | cmd.slot[2].vld | cmd.slot[3].vld;
	end

	assign push     = accept && has_out;
	assign push_cmd = cmd;

	// Held byte state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q <= BLANK_NONE;
			hc_q <= 1'b0;
		end else if (accept) begin
			hb_q <= in_last ? BLANK_NONE : nb_mid;
			hc_q <= in_last ? 1'b0 : nc_mid;
		end
	end

endmodule

FILE: rtl/qpe_fifo.sv
// Short command queue between front and back end.
module qpe_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qpe_pkg::qpe_cmd_t  push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               pop_valid,
	output qpe_pkg::qpe_cmd_t  pop_cmd
);
	import qpe_pkg::*;

	qpe_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd   = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/qpe_back.sv
// Back end: walks command pieces, adds soft breaks, emits one byte per unstalled cycle.
module qpe_back #(
	parameter int LINE_LIMIT = 76
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_mode,
	input  logic               cmd_valid,
	input  qpe_pkg::qpe_cmd_t  cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               out_run_end,
	output logic               out_stream_end
);
	import qpe_pkg::*;

	localparam logic [7:0] LIMIT = 8'(LINE_LIMIT);

	logic [SLOT_W-1:0] slot_q;
	logic [3:0]        pos_q;
	logic [6:0]        ll_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              run_end_q, stream_end_q;

	logic [SLOT_W-1:0] cur;
	logic              more;
	qpe_slot_t         s;
	logic [7:0]        sz1, sum_a, sum_b;
	logic [6:0]        l1, ll_fin;
	logic              brk_a, brk_b;
	logic [3:0]        last_pos, p;
	logic [7:0]        byte_c;
	logic              slot_done, cmd_done, adv;

	// Select the current piece: first valid slot at or after slot_q
	always_comb begin
		cur  = SLOT_W'(NUM_SLOTS-1);
		more = 1'b0;
		for (int i = NUM_SLOTS-1; i >= 0; i--) begin
			if (cmd.slot[i].vld && SLOT_W'(i) >= slot_q) begin
				cur = SLOT_W'(i);
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (cmd.slot[i].vld && SLOT_W'(i) > cur) begin
				more = 1'b1;
			end
		end
		s = cmd.slot[cur];
	end

	// Room checks and line length after the piece
	always_comb begin
		sz1   = (s.op == OP_LIT || s.op == OP_TRAIL) ? 8'd1 : 8'd3;
		sum_a = {1'b0, ll_q} + sz1;
		brk_a = !q_mode && (s.op != OP_HARD) && (sum_a >= LIMIT);
		l1    = brk_a ? sz1[6:0] : sum_a[6:0];
		sum_b = {1'b0, l1} + 8'd3;
		brk_b = !q_mode && (s.op == OP_TRAIL) && (sum_b >= LIMIT);
		case (s.op)
			OP_HARD:  ll_fin = '0;
			OP_TRAIL: ll_fin = brk_b ? 7'd3 : sum_b[6:0];
			default:  ll_fin = l1;
		endcase
		case (s.op)
			OP_LIT:  last_pos = 4'd6;
			OP_HARD: last_pos = 4'd7;
			default: last_pos = 4'd8;
		endcase
	end

	// Byte position: break one, break two, then body
	always_comb begin
		p = pos_q;
		if (p < 4'd3 && !brk_a) begin
			p = 4'd3;
		end
		if (p >= 4'd3 && p < 4'd6 && !brk_b) begin
			p = 4'd6;
		end
		case (p) inside
			4'd0, 4'd3: byte_c = CH_EQ;
			4'd1, 4'd4: byte_c = CH_CR;
			4'd2, 4'd5: byte_c = CH_LF;
			4'd6: begin
				if (s.op == OP_LIT) begin
					byte_c = s.data;
				end else if (s.op == OP_HARD) begin
					byte_c = CH_CR;
				end else begin
					byte_c = CH_EQ;
				end
			end
			4'd7:    byte_c = (s.op == OP_HARD) ? CH_LF : hex_digit(s.data[7:4]);
			default: byte_c = hex_digit(s.data[3:0]);
		endcase
		slot_done = (p == last_pos);
		cmd_done  = slot_done && !more;
		adv       = cmd_valid && (!out_valid_q || out_ready);
	end

	assign cmd_pop = adv && cmd_done;

	// Sequencer position and line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			pos_q  <= '0;
			ll_q   <= '0;
		end else if (adv) begin
			if (slot_done) begin
				pos_q <= '0;
				if (cmd_done) begin
					slot_q <= '0;
					ll_q   <= cmd.last ? 7'd0 : ll_fin;
				end else begin
					slot_q <= cur + 1'b1;
					ll_q   <= ll_fin;
				end
			end else begin
				pos_q <= p + 4'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q   <= byte_c;
			run_end_q    <= cmd_done;
			stream_end_q <= cmd_done && cmd.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign out_run_end    = run_end_q;
	assign out_stream_end = stream_end_q;

endmodule

FILE: rtl/quoted_printable_encoder.sv
// Quoted-printable encoder: one source byte in, encoded bytes out one per cycle while
// m_tready is high. An item's first encoded byte goes through the command queue and
// the output register. An item yields 1 byte if literal, 3 for =XX, plus 3 per soft
// break; held bytes yield none.
// Input is taken every cycle while the two-entry command queue has room.
// arst_n clears held bytes, line length, queue, q_mode and all literal map bits.
module quoted_printable_encoder #(
	parameter int LINE_LIMIT = 76
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] in_byte
	input  logic        s_tlast,    // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] out_byte
	output logic        m_tlast,    // out_run_end
	output logic        m_tuser,    // [0] out_stream_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import qpe_pkg::*;

	logic         q_mode_q;
	logic [255:0] lit_map_q;
	logic         push, full, pop, pop_valid;
	qpe_cmd_t     push_cmd, pop_cmd;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_mode_q  <= 1'b0;
			lit_map_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_Q_MODE:    q_mode_q           <= cfg_data[0];
				CFG_LIT_MAP_0: lit_map_q[63:0]    <= cfg_data;
				CFG_LIT_MAP_1: lit_map_q[127:64]  <= cfg_data;
				CFG_LIT_MAP_2: lit_map_q[191:128] <= cfg_data;
				CFG_LIT_MAP_3: lit_map_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	qpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.q_mode     (q_mode_q),
		.lit_map    (lit_map_q),
		.queue_full (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	qpe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	qpe_back #(
		.LINE_LIMIT (LINE_LIMIT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_mode         (q_mode_q),
		.cmd_valid      (pop_valid),
		.cmd            (pop_cmd),
		.cmd_pop        (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (m_tdata),
		.out_run_end    (m_tlast),
		.out_stream_end (m_tuser)
	);

endmodule

FILE: rtl/qpe_checker.sv
// Port-level checks of the encoder and their binding to the top level.
`include "quoted_printable_encoder_assert.svh"

module qpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser,
	input logic       cfg_ready
);

	// a stalled output byte stays put
	`QPE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output changed while stalled")

	// stream end only on the last byte of a run
	`QPE_ASSERT_NEVER(a_end_on_run_end, m_tvalid && m_tuser && !m_tlast, "stream end without run end")

	// configuration port never stalls
	`QPE_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (.*);

FILE: tb/sv/tb_quoted_printable_encoder.sv
// Self-checking quoted-printable encoder testbench: directed and random streams against a built-in encoder model.
module tb_quoted_printable_encoder;
	import qpe_pkg::*;

	localparam int LINE_LIMIT = 76;
	localparam int MAX_BYTES  = 16;
	localparam int CYCLE_CAP  = 600000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} src_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       stream_end;
	} enc_byte_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [63:0] cfg_data  = 64'd0;

	quoted_printable_encoder #(.LINE_LIMIT(LINE_LIMIT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Encoder mirror: configuration and line state
	logic        q_on;
	logic [63:0] lit_map [4];
	int          line_len;
	logic [1:0]  blank_held;
	logic        cr_held;

	logic [7:0]  step_bytes [$];
	enc_byte_t   encoded_q [$];
	src_byte_t   source_q [$];
	src_byte_t   drv_item;

	int  n_queued   = 0;
	int  n_taken    = 0;
	int  n_bad      = 0;
	int  cycles     = 0;
	int  src_gap    = 0;
	int  sink_gap   = 0;
	int  sink_hold  = 0;
	bit  src_taken  = 1'b0;
	bit  cfg_hit    = 1'b0;
	bit  calm       = 1'b0;

	function automatic void put_byte(input logic [7:0] b);
		if (step_bytes.size() < MAX_BYTES)
			step_bytes.push_back(b);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + n : 8'h41 + n - 8'd10;
	endfunction

	// Soft break when the piece would reach the line limit
	function automatic void fit_piece(input int size);
		if (!q_on && line_len + size >= LINE_LIMIT) begin
			put_byte(CH_EQ);
			put_byte(CH_CR);
			put_byte(CH_LF);
			line_len = 0;
		end
		line_len = (line_len + size) & 'h7F;
	endfunction

	function automatic void send_hex(input logic [7:0] c);
		fit_piece(3);
		put_byte(CH_EQ);
		put_byte(hex_char(c[7:4]));
		put_byte(hex_char(c[3:0]));
	endfunction

	function automatic void send_plain(input logic [7:0] c);
		fit_piece(1);
		put_byte(c);
	endfunction

	function automatic logic [7:0] held_char();
		return (blank_held == BLANK_TAB) ? CH_TAB : CH_SP;
	endfunction

	function automatic void flush_blank_plain();
		if (blank_held != BLANK_NONE) begin
			send_plain(held_char());
			blank_held = BLANK_NONE;
		end
	endfunction

	// Blank at end of line: one-byte check first, then the =XX piece
	function automatic void flush_blank_trailing();
		if (blank_held != BLANK_NONE) begin
			fit_piece(1);
			send_hex(held_char());
			blank_held = BLANK_NONE;
		end
	endfunction

	// Expected output bytes for one accepted source byte
	function automatic void encode_source(input logic [7:0] b, input logic last);
		bit   hard_break;
		int   n;
		enc_byte_t e;
		hard_break = 1'b0;
		step_bytes.delete();
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == CH_LF && !q_on) begin
				flush_blank_trailing();
				put_byte(CH_CR);
				put_byte(CH_LF);
				line_len = 0;
				hard_break = 1'b1;
			end else begin
				flush_blank_plain();
				send_hex(CH_CR);
			end
		end
		if (!hard_break) begin
			if (lit_map[b[7:6]][b[5:0]]) begin
				flush_blank_plain();
				if (b == CH_TAB)
					blank_held = BLANK_TAB;
				else if (b == CH_SP)
					blank_held = BLANK_SP;
				else
					send_plain(b);
			end else if (b == CH_CR && !q_on) begin
				cr_held = 1'b1;
			end else begin
				flush_blank_plain();
				send_hex(b);
			end
		end
		if (last) begin
			if (cr_held) begin
				flush_blank_plain();
				send_hex(CH_CR);
				cr_held = 1'b0;
			end else begin
				flush_blank_trailing();
			end
			line_len = 0;
		end
		n = step_bytes.size();
		for (int i = 0; i < n; i++) begin
			e.data       = step_bytes[i];
			e.run_end    = (i == n - 1);
			e.stream_end = (i == n - 1) && last;
			encoded_q.push_back(e);
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sender: new request at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !src_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				src_gap = $urandom_range(0, 18);
				s_tvalid <= 1'b0;
			end else if (source_q.size() > 0) begin
				drv_item = source_q.pop_front();
				s_tdata  <= drv_item.data;
				s_tlast  <= drv_item.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold when asked
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: check outputs, predict accepted requests, mirror register writes
	always @(posedge clk) begin
		enc_byte_t e;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end else if (arst_n) begin
			src_taken = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (encoded_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected output byte %02h last %0b end %0b",
							m_tdata, m_tlast, m_tuser);
				end else begin
					e = encoded_q.pop_front();
					if (m_tdata !== e.data || m_tlast !== e.run_end ||
							m_tuser !== e.stream_end) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch: expected %02h last %0b end %0b, got %02h last %0b end %0b",
								e.data, e.run_end, e.stream_end, m_tdata, m_tlast, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				encode_source(s_tdata, s_tlast);
				n_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_Q_MODE:    q_on = cfg_data[0];
					CFG_LIT_MAP_0: lit_map[0] = cfg_data;
					CFG_LIT_MAP_1: lit_map[1] = cfg_data;
					CFG_LIT_MAP_2: lit_map[2] = cfg_data;
					CFG_LIT_MAP_3: lit_map[3] = cfg_data;
					default: ;
				endcase
				cfg_hit = 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		src_byte_t s;
		s.data = b;
		s.last = last;
		source_q.push_back(s);
		n_queued++;
	endtask

	// Wait until every request is taken and every output byte has come
	task automatic wait_drain();
		while (n_taken != n_queued || encoded_q.size() != 0)
			@(negedge clk);
	endtask

	// Drained, plus time for work on bytes that produce no output
	task automatic wait_idle();
		wait_drain();
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		cfg_hit = 1'b0;
		@(negedge clk);
		while (!cfg_hit)
			@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_map(input logic [255:0] m);
		write_reg(CFG_LIT_MAP_0, m[63:0]);
		write_reg(CFG_LIT_MAP_1, m[127:64]);
		write_reg(CFG_LIT_MAP_2, m[191:128]);
		write_reg(CFG_LIT_MAP_3, m[255:192]);
	endtask

	// Usual quoted-printable literal set: printable ASCII but '=', plus tab and space
	function automatic logic [255:0] qp_literals();
		logic [255:0] m;
		for (int c = 0; c < 256; c++)
			m[c] = (c >= 33 && c <= 126 && c != 61) || c == 9 || c == 32;
		return m;
	endfunction

	function automatic logic [255:0] random_map();
		return {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Text-like random stream: mostly printable with blanks, line breaks and stray codes
	task automatic push_text(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				push_byte(8'($urandom_range(33, 126)), $urandom_range(0, 29) == 0);
			else if (r < 55)
				push_byte(CH_SP, $urandom_range(0, 29) == 0);
			else if (r < 62)
				push_byte(CH_TAB, $urandom_range(0, 29) == 0);
			else if (r < 67) begin
				push_byte(CH_CR, $urandom_range(0, 39) == 0);
				push_byte(CH_LF, $urandom_range(0, 29) == 0);
				i++;
			end else if (r < 70)
				push_byte(CH_CR, $urandom_range(0, 29) == 0);
			else if (r < 74)
				push_byte(CH_EQ, $urandom_range(0, 29) == 0);
			else if (r < 78)
				push_byte(CH_LF, $urandom_range(0, 29) == 0);
			else
				push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
		end
	endtask

	// Stimulus
	initial begin
		q_on       = 1'b0;
		lit_map    = '{default: 64'd0};
		line_len   = 0;
		blank_held = BLANK_NONE;
		cr_held    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: every byte escaped, CR LF a hard break, CR as the last byte
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(CH_TAB, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(CH_CR, 1'b1);
		wait_idle();

		// Usual literal set: trailing blanks, lone CR, blank and CR held together
		write_reg(CFG_Q_MODE, 64'd0);
		load_map(qp_literals());
		push_byte("a", 1'b0);
		push_byte(CH_TAB, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(CH_EQ, 1'b0);
		push_byte(CH_SP, 1'b1);
		push_byte(CH_CR, 1'b0);
		push_byte("x", 1'b0);
		push_byte(CH_SP, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte("y", 1'b0);
		push_byte(CH_TAB, 1'b1);
		// Q mode switched on while a space and a CR are held
		push_byte(CH_SP, 1'b0);
		push_byte(CH_CR, 1'b0);
		wait_idle();
		write_reg(CFG_Q_MODE, 64'd1);
		push_byte(CH_LF, 1'b1);
		wait_idle();

		// Literal CR never starts a hard break
		write_reg(CFG_Q_MODE, 64'd0);
		load_map(qp_literals() | (256'd1 << CH_CR));
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b1);
		wait_idle();

		// Random text, usual literal set, with a pause until all output is out
		load_map(qp_literals());
		push_text(20);
		wait_drain();
		push_text(20);
		wait_idle();

		// Q mode, upper data bits random
		write_reg(CFG_Q_MODE, {$urandom, $urandom} | 64'd1);
		push_text(40);
		wait_idle();

		// Every byte literal
		write_reg(CFG_Q_MODE, {$urandom, $urandom} & ~64'd1);
		load_map({256{1'b1}});
		push_text(40);
		wait_idle();

		// Every byte escaped: soft breaks come often
		load_map(256'd0);
		push_text(40);
		wait_idle();

		// Q mode with a random literal set
		write_reg(CFG_Q_MODE, 64'd1);
		load_map(random_map());
		push_text(40);
		wait_idle();

		// Receiver holds off long enough for the input side to back up
		write_reg(CFG_Q_MODE, 64'd0);
		load_map(qp_literals());
		sink_hold = 300;
		push_text(40);
		wait_idle();

		// Final stretch without idling on either side
		load_map(qp_literals() | random_map());
		calm = 1'b1;
		push_text(40);
		push_byte("z", 1'b1);
		wait_drain();
		repeat (20) @(negedge clk);

		n_bad += encoded_q.size();
		if (n_bad == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
